@@ rtl/core/cpcc_pkg.sv @@
// Shared types, constants and helpers for the class pair confusion counter.
package cpcc_pkg;

   localparam int MAX_CLASSES = 16;
   localparam int COUNT_WIDTH = 32;
   localparam int SLOT_W = $clog2(MAX_CLASSES);
   localparam int CLS_W = $clog2(MAX_CLASSES + 1);
   localparam int MATRIX_SIDE = MAX_CLASSES + 1;
   localparam int CELLS = MATRIX_SIDE * MATRIX_SIDE;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int SEARCH_STEPS = SLOT_W + 1;
   localparam int STEP_W = $clog2(SEARCH_STEPS + 1);
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   localparam logic [1:0] KIND_LOAD_ONE = 2'd0;
   localparam logic [1:0] KIND_LOAD_TWO = 2'd1;
   localparam logic [1:0] KIND_PAIR = 2'd2;
   localparam logic [1:0] KIND_READ = 2'd3;

   localparam logic [1:0] CSR_REPORT = 2'd0;
   localparam logic [1:0] CSR_COUNT_ONE = 2'd1;
   localparam logic [1:0] CSR_COUNT_TWO = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CLEAR, ST_SEARCH, ST_FINAL, ST_ENTRY, ST_CODE, ST_RD, ST_WR, ST_READ_WAIT
   } state_type;

   typedef struct packed {
      logic latch;
      logic clear_step;
      logic search_init;
      logic search_step;
      logic finalize;
      logic entry_read;
      logic code_calc;
      logic mem_read;
      logic mem_write;
      logic done;
   } ctrl_type;

   typedef struct packed {
      logic clear_last;
   } stat_type;

   // Compare of one value against one interval: 1 below, 0 inside, -1 above.
   function automatic logic [1:0] cmp_entry(logic signed [31:0] lo, logic signed [31:0] hi,
                                            logic signed [31:0] v);
      logic [1:0] r;
      if (v < lo) r = 2'b01;
      else if (lo < hi) r = (v < hi) ? 2'b00 : 2'b11;
      else r = (v > lo) ? 2'b11 : 2'b00;
      return r;
   endfunction

endpackage

@@ rtl/core/cpcc_ram.sv @@
// Generic single port RAM with registered read.
module cpcc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 289
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata <= mem_ff[addr];
   end
endmodule

@@ rtl/core/cpcc_ctrl.sv @@
// Controller state machine sequencing loads, searches and counter access.
module cpcc_ctrl import cpcc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [1:0] kind,
   input  stat_type   stat,
   output logic       busy,
   output ctrl_type   ctrl
);
   state_type state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         step_ff <= '0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      ctrl = '0;
      busy = 1'b1;
      unique case (state_ff)
         ST_CLEAR: begin
            ctrl.clear_step = 1'b1;
            if (stat.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               ctrl.latch = 1'b1;
               priority case (kind)
                  KIND_PAIR: begin
                     ctrl.search_init = 1'b1;
                     step_in = '0;
                     state_in = ST_SEARCH;
                  end
                  KIND_READ: state_in = ST_RD;
                  default: state_in = ST_READ_WAIT;
               endcase
            end
         end
         ST_SEARCH: begin
            ctrl.search_step = 1'b1;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(SEARCH_STEPS - 1)) state_in = ST_FINAL;
         end
         ST_FINAL: begin
            ctrl.finalize = 1'b1;
            state_in = ST_ENTRY;
         end
         ST_ENTRY: begin
            ctrl.entry_read = 1'b1;
            state_in = ST_CODE;
         end
         ST_CODE: begin
            ctrl.code_calc = 1'b1;
            state_in = ST_RD;
         end
         ST_RD: begin
            ctrl.mem_read = 1'b1;
            state_in = ST_WR;
         end
         ST_WR: begin
            ctrl.mem_write = 1'b1;
            ctrl.done = 1'b1;
            state_in = ST_IDLE;
         end
         ST_READ_WAIT: begin
            ctrl.done = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

`ifndef SYNTH
   a_clear_to_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR && stat.clear_last) |=> state_ff == ST_IDLE)
      else $error("clear pass did not end in idle");
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("not busy after accepting an item");
   a_done_single: assert property (@(posedge clock) disable iff (reset)
      ctrl.done |=> !ctrl.done)
      else $error("two results in a row");
`endif
endmodule

@@ rtl/core/cpcc_dp.sv @@
// Datapath: class tables, stepwise binary search, code and counter update.
module cpcc_dp import cpcc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  ctrl_type                 ctrl,
   output stat_type                 stat,
   input  logic                     cfg_report,
   input  logic [4:0]               cfg_count_one,
   input  logic [4:0]               cfg_count_two,
   input  logic [1:0]               kind,
   input  logic [3:0]               entry_slot,
   input  logic [3:0]               class_number,
   input  logic signed [31:0]       low_bound,
   input  logic signed [31:0]       high_bound,
   input  logic [15:0]              name_tag,
   input  logic signed [31:0]       value_one,
   input  logic signed [31:0]       value_two,
   input  logic [4:0]               read_row,
   input  logic [4:0]               read_col,
   input  logic                     clear_after_read,
   output logic [4:0]               class_one,
   output logic [4:0]               class_two,
   output logic signed [9:0]        combined_code,
   output logic                     counted,
   output logic [31:0]              cell_count
);
   logic signed [31:0] lo1_ff [MAX_CLASSES];
   logic signed [31:0] hi1_ff [MAX_CLASSES];
   logic [3:0]         cl1_ff [MAX_CLASSES];
   logic [15:0]        tg1_ff [MAX_CLASSES];
   logic signed [31:0] lo2_ff [MAX_CLASSES];
   logic signed [31:0] hi2_ff [MAX_CLASSES];
   logic [3:0]         cl2_ff [MAX_CLASSES];
   logic [15:0]        tg2_ff [MAX_CLASSES];

   logic [1:0] kind_ff;
   logic signed [31:0] v1_ff, v2_ff;
   logic [CLS_W-1:0] n1_ff, n2_ff;
   logic signed [CLS_W+1:0] a1_ff, b1_ff, a2_ff, b2_ff;
   logic hit1_ff, hit2_ff, done1_ff, done2_ff;
   logic [SLOT_W-1:0] s1_ff, s2_ff;
   logic [CLS_W-1:0] c1_ff, c2_ff;
   logic same_ff, count_ff, clr_ff, rd_ok_ff;
   logic [ADDR_W-1:0] addr_ff, clr_addr_ff;
   logic [9:0] code_ff;

   logic ram_we;
   logic [ADDR_W-1:0] ram_addr;
   logic [COUNT_WIDTH-1:0] ram_wdata, ram_rdata;

   cpcc_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(CELLS)) u_counts (
      .clock(clock), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
   );

   function automatic logic [CLS_W-1:0] eff(logic [4:0] c);
      return (c > 5'(MAX_CLASSES)) ? CLS_W'(MAX_CLASSES) : CLS_W'(c);
   endfunction

   assign stat.clear_last = (clr_addr_ff == ADDR_W'(CELLS - 1));

   // One search step: the caller gives the interval [a,b] and the table.
   logic signed [CLS_W+1:0] mid1, mid2;
   logic [1:0] r1, r2, fa1, fb1, fa2, fb2;
   logic [SLOT_W-1:0] m1i, m2i, a1i, b1i, a2i, b2i;
   always_comb begin
      mid1 = a1_ff + ((b1_ff - a1_ff) >>> 1);
      mid2 = a2_ff + ((b2_ff - a2_ff) >>> 1);
      m1i = mid1[SLOT_W-1:0];
      m2i = mid2[SLOT_W-1:0];
      r1 = cmp_entry(lo1_ff[m1i], hi1_ff[m1i], v1_ff);
      r2 = cmp_entry(lo2_ff[m2i], hi2_ff[m2i], v2_ff);
      a1i = a1_ff[SLOT_W-1:0];
      b1i = b1_ff[SLOT_W-1:0];
      a2i = a2_ff[SLOT_W-1:0];
      b2i = b2_ff[SLOT_W-1:0];
      fa1 = cmp_entry(lo1_ff[a1i], hi1_ff[a1i], v1_ff);
      fb1 = cmp_entry(lo1_ff[b1i], hi1_ff[b1i], v1_ff);
      fa2 = cmp_entry(lo2_ff[a2i], hi2_ff[a2i], v2_ff);
      fb2 = cmp_entry(lo2_ff[b2i], hi2_ff[b2i], v2_ff);
   end

   logic signed [CLS_W+1:0] n1s, n2s;
   assign n1s = (CLS_W+2)'(n1_ff);
   assign n2s = (CLS_W+2)'(n2_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (ctrl.clear_step) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
      end
      if (ctrl.latch) begin
         kind_ff <= kind;
         v1_ff <= value_one;
         v2_ff <= value_two;
         clr_ff <= clear_after_read;
         rd_ok_ff <= (read_row <= 5'(MAX_CLASSES)) && (read_col <= 5'(MAX_CLASSES));
         addr_ff <= ADDR_W'(read_row) * ADDR_W'(MATRIX_SIDE) + ADDR_W'(read_col);
         class_one <= '0;
         class_two <= '0;
         combined_code <= '0;
         counted <= 1'b0;
         cell_count <= '0;
         if (kind == KIND_LOAD_ONE) begin
            lo1_ff[entry_slot] <= low_bound;
            hi1_ff[entry_slot] <= high_bound;
            cl1_ff[entry_slot] <= class_number;
            tg1_ff[entry_slot] <= name_tag;
         end
         if (kind == KIND_LOAD_TWO) begin
            lo2_ff[entry_slot] <= low_bound;
            hi2_ff[entry_slot] <= high_bound;
            cl2_ff[entry_slot] <= class_number;
            tg2_ff[entry_slot] <= name_tag;
         end
      end
      if (ctrl.search_init) begin
         n1_ff <= eff(cfg_count_one);
         n2_ff <= eff(cfg_count_two);
         a1_ff <= '0;
         a2_ff <= '0;
         b1_ff <= (CLS_W+2)'(eff(cfg_count_one)) - 1'b1;
         b2_ff <= (CLS_W+2)'(eff(cfg_count_two)) - 1'b1;
         done1_ff <= (cfg_count_one == 5'd0);
         done2_ff <= (cfg_count_two == 5'd0);
         hit1_ff <= 1'b0;
         hit2_ff <= 1'b0;
      end
      if (ctrl.search_step) begin
         if (!done1_ff && a1_ff < b1_ff) begin
            if (r1 == 2'b01) b1_ff <= (b1_ff > mid1) ? mid1 : b1_ff - 1'b1;
            else if (r1 == 2'b11) a1_ff <= (a1_ff < mid1) ? mid1 : a1_ff + 1'b1;
            else begin
               done1_ff <= 1'b1;
               hit1_ff <= 1'b1;
               s1_ff <= m1i;
            end
         end
         if (!done2_ff && a2_ff < b2_ff) begin
            if (r2 == 2'b01) b2_ff <= (b2_ff > mid2) ? mid2 : b2_ff - 1'b1;
            else if (r2 == 2'b11) a2_ff <= (a2_ff < mid2) ? mid2 : a2_ff + 1'b1;
            else begin
               done2_ff <= 1'b1;
               hit2_ff <= 1'b1;
               s2_ff <= m2i;
            end
         end
      end
      if (ctrl.finalize) begin
         if (!done1_ff) begin
            if (a1_ff >= 0 && a1_ff < n1s && fa1 == 2'b00) begin
               hit1_ff <= 1'b1;
               s1_ff <= a1i;
            end else if (a1_ff != b1_ff && b1_ff >= 0 && b1_ff < n1s && fb1 == 2'b00) begin
               hit1_ff <= 1'b1;
               s1_ff <= b1i;
            end
         end
         if (!done2_ff) begin
            if (a2_ff >= 0 && a2_ff < n2s && fa2 == 2'b00) begin
               hit2_ff <= 1'b1;
               s2_ff <= a2i;
            end else if (a2_ff != b2_ff && b2_ff >= 0 && b2_ff < n2s && fb2 == 2'b00) begin
               hit2_ff <= 1'b1;
               s2_ff <= b2i;
            end
         end
      end
      if (ctrl.entry_read) begin
         c1_ff <= (hit1_ff && CLS_W'(cl1_ff[s1_ff]) < n1_ff) ? CLS_W'(cl1_ff[s1_ff]) : n1_ff;
         c2_ff <= (hit2_ff && CLS_W'(cl2_ff[s2_ff]) < n2_ff) ? CLS_W'(cl2_ff[s2_ff]) : n2_ff;
         same_ff <= tg1_ff[s1_ff] == tg2_ff[s2_ff];
      end
      if (ctrl.code_calc) begin
         if (c1_ff == n1_ff || c2_ff == n2_ff) begin
            count_ff <= cfg_report || !(c1_ff == n1_ff && c2_ff == n2_ff);
         end else begin
            count_ff <= cfg_report || !same_ff;
         end
         code_ff <= (10'(n2_ff) + 10'd1) * 10'(c1_ff) + 10'(c2_ff);
         addr_ff <= ADDR_W'(c1_ff) * ADDR_W'(MATRIX_SIDE) + ADDR_W'(c2_ff);
      end
      if (ctrl.done && kind_ff == KIND_PAIR) begin
         class_one <= 5'(c1_ff);
         class_two <= 5'(c2_ff);
         counted <= count_ff;
         combined_code <= count_ff ? code_ff : -10'sd1;
      end
      if (ctrl.done && kind_ff == KIND_READ && rd_ok_ff) begin
         cell_count <= 32'(ram_rdata);
      end
   end

   always_comb begin
      ram_we = 1'b0;
      ram_addr = addr_ff;
      ram_wdata = '0;
      if (ctrl.clear_step) begin
         ram_we = 1'b1;
         ram_addr = clr_addr_ff;
      end else if (ctrl.mem_write) begin
         if (kind_ff == KIND_PAIR) begin
            ram_we = count_ff && (ram_rdata != COUNT_MAX);
            ram_wdata = ram_rdata + 1'b1;
         end else begin
            ram_we = rd_ok_ff && clr_ff;
         end
      end
   end

`ifndef SYNTH
   a_class_range: assert property (@(posedge clock) disable iff (reset)
      ctrl.code_calc |-> (c1_ff <= n1_ff && c2_ff <= n2_ff))
      else $error("class beyond count");
   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (ctrl.clear_step || ctrl.mem_write))
      else $error("stray counter write");
`endif
endmodule

@@ rtl/core/class_pair_confusion_counter_core.sv @@
// Top level of the class pair confusion counter.
//  Channel | Ports                              | Direction
//  item    | start, busy, req_*                 | in, busy back
//  result  | rsp_valid, rsp_*                   | out, one cycle strobe
//  config  | csr_write, csr_index, csr_data     | in
// A pixel pair runs five binary search steps, a closing check, the class table read,
// the code, and a counter read and write on the single memory port. After reset the
// counter memory is cleared, one cell a cycle, with busy high. The receiver cannot
// stall.
module class_pair_confusion_counter_core import cpcc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_kind,
   input  logic [3:0]         req_entry_slot,
   input  logic [3:0]         req_class_number,
   input  logic signed [31:0] req_low_bound,
   input  logic signed [31:0] req_high_bound,
   input  logic [15:0]        req_name_tag,
   input  logic signed [31:0] req_value_one,
   input  logic signed [31:0] req_value_two,
   input  logic [4:0]         req_read_row,
   input  logic [4:0]         req_read_col,
   input  logic               req_clear_after_read,
   output logic               rsp_valid,
   output logic [4:0]         rsp_class_one,
   output logic [4:0]         rsp_class_two,
   output logic signed [9:0]  rsp_combined_code,
   output logic               rsp_counted,
   output logic [31:0]        rsp_cell_count,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [4:0]         csr_data
);
   ctrl_type ctrl;
   stat_type stat;
   logic report_ff;
   logic [4:0] count_one_ff, count_two_ff;
   logic valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         report_ff <= 1'b1;
         count_one_ff <= '0;
         count_two_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= ctrl.done;
         if (csr_write) begin
            unique case (csr_index)
               CSR_REPORT: report_ff <= csr_data[0];
               CSR_COUNT_ONE: count_one_ff <= csr_data;
               CSR_COUNT_TWO: count_two_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end
   assign rsp_valid = valid_ff;

   cpcc_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .kind(req_kind),
      .stat(stat), .busy(busy), .ctrl(ctrl)
   );

   cpcc_dp u_dp (
      .clock(clock), .reset(reset), .ctrl(ctrl), .stat(stat),
      .cfg_report(report_ff), .cfg_count_one(count_one_ff), .cfg_count_two(count_two_ff),
      .kind(req_kind), .entry_slot(req_entry_slot), .class_number(req_class_number),
      .low_bound(req_low_bound), .high_bound(req_high_bound), .name_tag(req_name_tag),
      .value_one(req_value_one), .value_two(req_value_two),
      .read_row(req_read_row), .read_col(req_read_col),
      .clear_after_read(req_clear_after_read),
      .class_one(rsp_class_one), .class_two(rsp_class_two),
      .combined_code(rsp_combined_code), .counted(rsp_counted),
      .cell_count(rsp_cell_count)
   );

`ifndef SYNTH
   a_result_once: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$past(rsp_valid))
      else $error("result strobe held two cycles");
`endif
endmodule

@@ bench/class_pair_confusion_counter_core_tb.sv @@
// Self-checking testbench for the class pair confusion counter core.
`timescale 1ns / 100ps

module class_pair_confusion_counter_core_tb import cpcc_pkg::*; ();

   typedef struct {
      logic [1:0]         kind;
      logic [3:0]         entry_slot;
      logic [3:0]         class_number;
      logic signed [31:0] low_bound;
      logic signed [31:0] high_bound;
      logic [15:0]        name_tag;
      logic signed [31:0] value_one;
      logic signed [31:0] value_two;
      logic [4:0]         read_row;
      logic [4:0]         read_col;
      logic               clear_after_read;
   } pixel_item_type;

   typedef struct {
      logic [4:0]        class_one;
      logic [4:0]        class_two;
      logic signed [9:0] combined_code;
      logic              counted;
      logic [31:0]       cell_count;
   } class_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [1:0]         req_kind = '0;
   logic [3:0]         req_entry_slot = '0;
   logic [3:0]         req_class_number = '0;
   logic signed [31:0] req_low_bound = '0;
   logic signed [31:0] req_high_bound = '0;
   logic [15:0]        req_name_tag = '0;
   logic signed [31:0] req_value_one = '0;
   logic signed [31:0] req_value_two = '0;
   logic [4:0]         req_read_row = '0;
   logic [4:0]         req_read_col = '0;
   logic               req_clear_after_read = 1'b0;
   logic               rsp_valid;
   logic [4:0]         rsp_class_one;
   logic [4:0]         rsp_class_two;
   logic signed [9:0]  rsp_combined_code;
   logic               rsp_counted;
   logic [31:0]        rsp_cell_count;
   logic               csr_write = 1'b0;
   logic [1:0]         csr_index = '0;
   logic [4:0]         csr_data = '0;

   class_pair_confusion_counter_core dut (.*);

   always #5 clock = ~clock;

   // Predictor state: index 0 is table one, index 1 is table two.
   logic signed [31:0] low_tab [2][MAX_CLASSES];
   logic signed [31:0] high_tab [2][MAX_CLASSES];
   logic [3:0]         class_tab [2][MAX_CLASSES];
   logic [15:0]        tag_tab [2][MAX_CLASSES];
   logic [COUNT_WIDTH-1:0] pair_cells [MATRIX_SIDE][MATRIX_SIDE];
   logic               mdl_report = 1'b1;
   logic [4:0]         mdl_count [2] = '{5'd0, 5'd0};

   class_result_type expected_results [$];
   int errors = 0;
   int n_pairs = 0, n_counted = 0, n_reads = 0, n_loads = 0, n_checked = 0;
   bit allow_gaps = 1'b1;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      errors++;
      $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
   endtask

   function automatic int interval_order(int t, int s, logic signed [31:0] v);
      if (v < low_tab[t][s]) return 1;
      if (low_tab[t][s] < high_tab[t][s]) return (v < high_tab[t][s]) ? 0 : -1;
      return (v > low_tab[t][s]) ? -1 : 0;
   endfunction

   function automatic int find_slot(int t, int n, logic signed [31:0] v);
      int a, b, i, c;
      if (n == 0) return -1;
      a = 0;
      b = n - 1;
      while (a < b) begin
         i = a + (b - a) / 2;
         c = interval_order(t, i, v);
         if (c > 0) b = (b > i) ? i : b - 1;
         else if (c < 0) a = (a < i) ? i : a + 1;
         else return i;
      end
      if (a >= 0 && a < n && interval_order(t, a, v) == 0) return a;
      if (a != b && b >= 0 && b < n && interval_order(t, b, v) == 0) return b;
      return -1;
   endfunction

   function automatic class_result_type classify_and_count(pixel_item_type it);
      class_result_type r;
      int n [2];
      int s [2];
      int c [2];
      int t;
      bit same;
      r = '{default: '0};
      case (it.kind)
         KIND_LOAD_ONE, KIND_LOAD_TWO: begin
            t = (it.kind == KIND_LOAD_TWO);
            low_tab[t][it.entry_slot] = it.low_bound;
            high_tab[t][it.entry_slot] = it.high_bound;
            class_tab[t][it.entry_slot] = it.class_number;
            tag_tab[t][it.entry_slot] = it.name_tag;
         end
         KIND_PAIR: begin
            for (t = 0; t < 2; t++) begin
               n[t] = (mdl_count[t] > MAX_CLASSES) ? MAX_CLASSES : int'(mdl_count[t]);
               s[t] = find_slot(t, n[t], t ? it.value_two : it.value_one);
               c[t] = n[t];
               if (s[t] >= 0 && class_tab[t][s[t]] < n[t]) c[t] = class_tab[t][s[t]];
            end
            if (c[0] == n[0] || c[1] == n[1]) same = (c[0] == n[0] && c[1] == n[1]);
            else same = (tag_tab[0][s[0]] == tag_tab[1][s[1]]);
            r.class_one = 5'(c[0]);
            r.class_two = 5'(c[1]);
            if (mdl_report || !same) begin
               if (pair_cells[c[0]][c[1]] != COUNT_MAX)
                  pair_cells[c[0]][c[1]] = pair_cells[c[0]][c[1]] + 1'b1;
               r.combined_code = 10'((n[1] + 1) * c[0] + c[1]);
               r.counted = 1'b1;
            end else begin
               r.combined_code = -10'sd1;
            end
         end
         default: begin
            if (it.read_row <= MAX_CLASSES && it.read_col <= MAX_CLASSES) begin
               r.cell_count = pair_cells[it.read_row][it.read_col];
               if (it.clear_after_read) pair_cells[it.read_row][it.read_col] = '0;
            end
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      class_result_type want;
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected result", 32'd1, 32'd0);
         end else begin
            want = expected_results.pop_front();
            n_checked++;
            if (rsp_class_one !== want.class_one)
               report_mismatch("class_one", 32'(rsp_class_one), 32'(want.class_one));
            if (rsp_class_two !== want.class_two)
               report_mismatch("class_two", 32'(rsp_class_two), 32'(want.class_two));
            if (rsp_combined_code !== want.combined_code)
               report_mismatch("combined_code", 32'(rsp_combined_code),
                               32'(want.combined_code));
            if (rsp_counted !== want.counted)
               report_mismatch("counted", 32'(rsp_counted), 32'(want.counted));
            if (rsp_cell_count !== want.cell_count)
               report_mismatch("cell_count", rsp_cell_count, want.cell_count);
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance, or later when a random gap follows.
   task automatic send_item(input pixel_item_type it);
      int gap;
      req_kind = it.kind;
      req_entry_slot = it.entry_slot;
      req_class_number = it.class_number;
      req_low_bound = it.low_bound;
      req_high_bound = it.high_bound;
      req_name_tag = it.name_tag;
      req_value_one = it.value_one;
      req_value_two = it.value_two;
      req_read_row = it.read_row;
      req_read_col = it.read_col;
      req_clear_after_read = it.clear_after_read;
      start = 1'b1;
      do @(posedge clock); while (busy);
      expected_results.push_back(classify_and_count(it));
      case (it.kind)
         KIND_PAIR: n_pairs++;
         KIND_READ: n_reads++;
         default: n_loads++;
      endcase
      if (it.kind == KIND_PAIR && expected_results[$].counted) n_counted++;
      @(negedge clock);
      if (allow_gaps) begin
         gap = $urandom_range(0, 99);
         if (gap < 55) gap = 0;
         else if (gap < 92) gap = $urandom_range(1, 3);
         else gap = $urandom_range(8, 40);
         if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   task automatic wait_idle();
      start = 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
      repeat (15) @(negedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [4:0] data);
      wait_idle();
      csr_write = 1'b1;
      csr_index = idx;
      csr_data = data;
      @(negedge clock);
      csr_write = 1'b0;
      if (idx == CSR_REPORT) mdl_report = data[0];
      else if (idx == CSR_COUNT_ONE) mdl_count[0] = data;
      else if (idx == CSR_COUNT_TWO) mdl_count[1] = data;
   endtask

   function automatic pixel_item_type make_load(int t, int slot, logic signed [31:0] lo,
                                                logic signed [31:0] hi, int cls, int tag);
      pixel_item_type it;
      it = '{default: '0};
      it.kind = t ? KIND_LOAD_TWO : KIND_LOAD_ONE;
      it.entry_slot = 4'(slot);
      it.class_number = 4'(cls);
      it.low_bound = lo;
      it.high_bound = hi;
      it.name_tag = 16'(tag);
      it.read_row = 5'($urandom);
      it.read_col = 5'($urandom);
      it.value_one = $urandom;
      it.value_two = $urandom;
      return it;
   endfunction

   function automatic pixel_item_type make_pair(logic signed [31:0] v1,
                                                logic signed [31:0] v2);
      pixel_item_type it;
      it = '{default: '0};
      it.kind = KIND_PAIR;
      it.value_one = v1;
      it.value_two = v2;
      it.entry_slot = 4'($urandom);
      it.low_bound = $urandom;
      it.name_tag = 16'($urandom);
      return it;
   endfunction

   function automatic pixel_item_type make_read(int row, int col, bit clr);
      pixel_item_type it;
      it = '{default: '0};
      it.kind = KIND_READ;
      it.read_row = 5'(row);
      it.read_col = 5'(col);
      it.clear_after_read = clr;
      return it;
   endfunction

   // Fills one table with random intervals, sorted by low bound when asked, some of them single points.
   task automatic load_random_table(int t, bit sorted);
      logic signed [31:0] lows [$];
      logic signed [31:0] hi;
      int k;
      for (k = 0; k < MAX_CLASSES; k++) lows.push_back($urandom_range(0, 7) == 0 ?
                                                         $urandom : $urandom_range(0, 4000) - 2000);
      if (sorted) lows.sort();
      for (k = 0; k < MAX_CLASSES; k++) begin
         case ($urandom_range(0, 5))
            0: hi = lows[k];
            1: hi = $urandom;
            default: hi = lows[k] + $urandom_range(1, 300);
         endcase
         send_item(make_load(t, k, lows[k], hi, $urandom_range(0, 15), $urandom_range(0, 5)));
      end
   endtask

   function automatic logic signed [31:0] pick_value(int t);
      int s;
      s = $urandom_range(0, MAX_CLASSES - 1);
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
         2: return high_tab[t][s] + $urandom_range(0, 2) - 1;
         3: return low_tab[t][s] - 1;
         default: return low_tab[t][s] + $urandom_range(0, 150);
      endcase
   endfunction

   task automatic test_table_setup();
      int k;
      logic signed [31:0] lo;
      for (k = 0; k < MAX_CLASSES; k++) begin
         lo = (k == 0) ? 32'sh80000000 : (k == 15) ? 32'sh7fffffc0 : k * 100 - 800;
         send_item(make_load(0, k, lo, (k == 7) ? lo : lo + 50, k, k));
         send_item(make_load(1, k, lo, (k == 9) ? lo - 5 : lo + 50, 15 - k,
                             (k == 3) ? 16'hffff : k));
      end
   endtask

   task automatic test_directed();
      write_csr(CSR_COUNT_ONE, 5'd16);
      write_csr(CSR_COUNT_TWO, 5'd16);
      send_item(make_pair(32'sh80000000, 32'sh7fffffff));
      send_item(make_pair(32'sh7fffffff, 32'sh7fffffc0));
      send_item(make_pair(-100, -75));
      send_item(make_pair(-1, -1));
      send_item(make_pair(0, 100));
      send_item(make_pair(-1000, 5000));
      send_item(make_pair(-100, -95));
      write_csr(CSR_REPORT, 5'd0);
      send_item(make_pair(-500, -500));
      send_item(make_pair(-1000, 5000));
      send_item(make_pair(-500, 210));
      write_csr(CSR_COUNT_ONE, 5'd31);
      write_csr(CSR_COUNT_TWO, 5'd5);
      send_item(make_pair(-700, -200));
      send_item(make_pair(600, -790));
      write_csr(CSR_COUNT_ONE, 5'd0);
      write_csr(CSR_COUNT_TWO, 5'd0);
      send_item(make_pair(3, 4));
      write_csr(CSR_REPORT, 5'd1);
      send_item(make_pair(3, 4));
      send_item(make_read(0, 0, 1'b1));
      send_item(make_read(0, 0, 1'b0));
      send_item(make_read(16, 16, 1'b0));
      send_item(make_read(17, 2, 1'b1));
      send_item(make_read(31, 31, 1'b1));
   endtask

   task automatic test_random(int phases, int per_phase);
      int p, k, r;
      pixel_item_type it;
      for (p = 0; p < phases; p++) begin
         write_csr(CSR_REPORT, 5'($urandom_range(0, 1)));
         r = $urandom_range(0, 5);
         write_csr(CSR_COUNT_ONE, r == 0 ? 5'd0 : r == 1 ? 5'd31 : 5'($urandom_range(1, 17)));
         r = $urandom_range(0, 5);
         write_csr(CSR_COUNT_TWO, r == 0 ? 5'd0 : r == 1 ? 5'd16 : 5'($urandom_range(1, 20)));
         allow_gaps = (p % 3 != 1);
         if (p % 2 == 0) begin
            load_random_table(0, p % 4 != 2);
            load_random_table(1, 1'b1);
         end
         for (k = 0; k < per_phase; k++) begin
            r = $urandom_range(0, 99);
            if (r < 65) it = make_pair(pick_value(0), pick_value(1));
            else if (r < 90) it = make_read($urandom_range(0, 99) < 90 ?
                                            $urandom_range(0, 16) : $urandom_range(17, 31),
                                            $urandom_range(0, 17), $urandom_range(0, 1));
            else it = make_load($urandom_range(0, 1), $urandom_range(0, 15), $urandom,
                                $urandom, $urandom_range(0, 15), $urandom);
            send_item(it);
         end
         if (p == 2) wait_idle();
      end
   endtask

   initial begin
      int k;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      for (k = 0; k < CELLS; k++) pair_cells[k / MATRIX_SIDE][k % MATRIX_SIDE] = '0;
      test_table_setup();
      test_directed();
      test_random(6, 110);
      wait_idle();
      repeat (30) @(negedge clock);
      if (expected_results.size() != 0)
         report_mismatch("results never arrived", 32'(expected_results.size()), 32'd0);
      $display("Covered %0d pixel pairs (%0d counted), %0d cell reads, %0d table loads.",
               n_pairs, n_counted, n_reads, n_loads);
      $display("Checked %0d results, %0d mismatches.", n_checked, errors);
      if (errors == 0) $display("class_pair_confusion_counter_core verification clean");
      else $display("class_pair_confusion_counter_core verification failed");
      $finish;
   end

   initial begin
      #5ms;
      $display("class_pair_confusion_counter_core verification failed");
      $finish;
   end

endmodule
